// File: hdl/mfsl_pkg.sv
// Package for the message FIFO with size limits: beat payload structs,
// command and status codes, register indexes and controller states.
// No dependencies.
`timescale 1ns / 1ps

package mfsl_pkg;

  // Fixed field widths of the command and result beats.
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BUF_LEN_W = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned FREE_W    = 11;
  localparam int unsigned MSG_LEN_W = 7;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  // Register indexes (byte address divided by four).
  localparam logic [REG_IDX_W-1:0] REG_MAX_SEG  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WR_NONBL = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RD_NONBL = 2'd2;

  // Command codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_STAGE  = 2'd0,
    MODE_COMMIT = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_WAIT   = 3'd1,
    ST_AGAIN  = 3'd2,
    ST_BADLEN = 3'd3,
    ST_SMALL  = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_COMMIT,
    S_RD_LEN,
    S_RD_DATA
  } state_e;

  // Command beat.
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [BYTE_W-1:0]    data_byte;
    logic [BUF_LEN_W-1:0] length;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [BYTE_W-1:0]    out_byte;
    logic                 last;
    logic [FREE_W-1:0]    free_space;
    logic [MSG_LEN_W-1:0] message_length;
  } res_t;

endpackage

// File: hdl/message_fifo_with_size_limits_core.sv
// Message FIFO with all-or-nothing commit and read, built around three
// synchronous memories (staging buffer, byte store, length queue).
// Depends on mfsl_pkg.
//
// Channel   Direction  Handshake                       Payload
// command   in         start_i, accepted when !busy_o  cmd_i (cmd_t)
// result    out        res_strobe_o, one cycle a beat  res_o (res_t)
// config    in/out     APB: psel, penable, pwrite      paddr, pwdata, prdata
//
// Stage, bad or refused commit, unused code and a read refused at once never go busy.
// A good commit reads each staged byte from the staging buffer and writes it to the byte
// store through the memory read latency, then pushes the length onto the length queue.
// A good read first reads the head length from the length queue, then does one byte
// store read per byte; a buffer too small ends right after the length read.
// Reset clears all pointers and counters; the memories need no clearing pass.
// busy_o is high while a commit or read is in flight; results cannot stall.
`timescale 1ns / 1ps

module message_fifo_with_size_limits_core
  import mfsl_pkg::*;
#(
  parameter int unsigned SLOT_BYTES        = 1024,
  parameter int unsigned MAX_MESSAGE_BYTES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Command channel
  input  logic                  start_i,
  input  cmd_t                  cmd_i,
  output logic                  busy_o,
  // Result channel
  output logic                  res_strobe_o,
  output res_t                  res_o,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PW  = $clog2(SLOT_BYTES);
  localparam int unsigned UW  = $clog2(SLOT_BYTES + 1);
  localparam int unsigned SCW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned SAW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
  localparam logic [UW-1:0]        SlotFull = UW'(SLOT_BYTES);
  localparam logic [PW-1:0]        PtrLast  = PW'(SLOT_BYTES - 1);
  localparam logic [SCW-1:0]       StgFull  = SCW'(MAX_MESSAGE_BYTES);
  localparam logic [MSG_LEN_W-1:0] MaxSegLim = MSG_LEN_W'(MAX_MESSAGE_BYTES);

  // Circular pointer increment.
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  // Memories.
  logic [BYTE_W-1:0]    stg_mem [MAX_MESSAGE_BYTES];
  logic [BYTE_W-1:0]    bs_mem  [SLOT_BYTES];
  logic [MSG_LEN_W-1:0] lq_mem  [SLOT_BYTES];

  // Control and datapath registers.
  state_e               state_q, state_d;
  logic [PW-1:0]        byte_head_q, byte_head_d, byte_tail_q, byte_tail_d;
  logic [PW-1:0]        len_head_q, len_head_d, len_tail_q, len_tail_d;
  logic [UW-1:0]        msg_cnt_q, msg_cnt_d, used_q, used_d;
  logic [SCW-1:0]       stg_cnt_q, stg_cnt_d;
  logic                 stg_ovf_q, stg_ovf_d;
  logic [SCW-1:0]       xfer_len_q, xfer_len_d, issue_q, issue_d;
  logic                 pend_q, pend_d;
  logic [BUF_LEN_W-1:0] buf_len_q, buf_len_d;
  logic                 res_vld_q, res_vld_d;
  res_t                 res_q, res_d;
  logic [MSG_LEN_W-1:0] max_seg_q;
  logic                 wr_nonbl_q, rd_nonbl_q;

  // Memory access controls.
  logic                 stg_we, stg_re, bs_we, bs_re, lq_we, lq_re;
  logic [BYTE_W-1:0]    stg_rdata_q, bs_rdata_q;
  logic [MSG_LEN_W-1:0] lq_rdata_q;

  logic                 accept;
  logic [UW-1:0]        free_now;
  logic                 cmt_bad, cmt_nospace;
  logic [MSG_LEN_W-1:0] cfg_max_seg;
  logic                 cfg_wr;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign free_now = SlotFull - used_q;

  // Commit checks on the staged message.
  assign cmt_bad = stg_ovf_q || (stg_cnt_q == '0) ||
                   (MSG_LEN_W'(stg_cnt_q) > max_seg_q);
  assign cmt_nospace = (UW'(stg_cnt_q) > free_now) || (msg_cnt_q >= SlotFull);

  // Next state, pointer updates, memory controls and result beat.
  always_comb begin
    state_d     = state_q;
    byte_head_d = byte_head_q;
    byte_tail_d = byte_tail_q;
    len_head_d  = len_head_q;
    len_tail_d  = len_tail_q;
    msg_cnt_d   = msg_cnt_q;
    used_d      = used_q;
    stg_cnt_d   = stg_cnt_q;
    stg_ovf_d   = stg_ovf_q;
    xfer_len_d  = xfer_len_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    buf_len_d   = buf_len_q;
    res_vld_d   = 1'b0;
    stg_we      = 1'b0;
    stg_re      = 1'b0;
    bs_we       = 1'b0;
    bs_re       = 1'b0;
    lq_we       = 1'b0;
    lq_re       = 1'b0;
    res_d.status         = ST_OK;
    res_d.out_byte       = '0;
    res_d.last           = 1'b1;
    res_d.message_length = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.mode)
            MODE_STAGE: begin
              res_vld_d = 1'b1;
              if (stg_cnt_q < StgFull) begin
                stg_we    = 1'b1;
                stg_cnt_d = stg_cnt_q + 1'b1;
              end else begin
                stg_ovf_d = 1'b1;
              end
            end
            MODE_COMMIT: begin
              if (cmt_bad) begin
                res_vld_d    = 1'b1;
                res_d.status = ST_BADLEN;
                stg_cnt_d    = '0;
                stg_ovf_d    = 1'b0;
              end else if (cmt_nospace) begin
                res_vld_d = 1'b1;
                if (wr_nonbl_q) begin
                  res_d.status = ST_AGAIN;
                  stg_cnt_d    = '0;
                  stg_ovf_d    = 1'b0;
                end else begin
                  res_d.status = ST_WAIT;
                end
              end else begin
                xfer_len_d = stg_cnt_q;
                issue_d    = '0;
                state_d    = S_COMMIT;
              end
            end
            MODE_READ: begin
              if (cmd_i.length == '0) begin
                res_vld_d    = 1'b1;
                res_d.status = ST_BADLEN;
              end else if (msg_cnt_q == '0) begin
                res_vld_d    = 1'b1;
                res_d.status = rd_nonbl_q ? ST_AGAIN : ST_WAIT;
              end else begin
                lq_re     = 1'b1;
                buf_len_d = cmd_i.length;
                state_d   = S_RD_LEN;
              end
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end

      // Copy staged bytes into the byte store, one read and one write a cycle.
      S_COMMIT: begin
        if (issue_q != xfer_len_q) begin
          stg_re  = 1'b1;
          issue_d = issue_q + 1'b1;
          pend_d  = 1'b1;
        end
        if (pend_q) begin
          bs_we       = 1'b1;
          byte_tail_d = ptr_inc(byte_tail_q);
          if (issue_q == xfer_len_q) begin
            lq_we                = 1'b1;
            len_tail_d           = ptr_inc(len_tail_q);
            msg_cnt_d            = msg_cnt_q + 1'b1;
            used_d               = used_q + UW'(xfer_len_q);
            stg_cnt_d            = '0;
            stg_ovf_d            = 1'b0;
            res_vld_d            = 1'b1;
            res_d.message_length = MSG_LEN_W'(xfer_len_q);
            state_d              = S_IDLE;
          end
        end
      end

      // Head length is back from the length queue.
      S_RD_LEN: begin
        if (BUF_LEN_W'(lq_rdata_q) > buf_len_q) begin
          res_vld_d    = 1'b1;
          res_d.status = ST_SMALL;
          state_d      = S_IDLE;
        end else begin
          len_head_d = ptr_inc(len_head_q);
          msg_cnt_d  = msg_cnt_q - 1'b1;
          used_d     = used_q - UW'(lq_rdata_q);
          if (lq_rdata_q == '0) begin
            res_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else begin
            xfer_len_d = SCW'(lq_rdata_q);
            issue_d    = '0;
            state_d    = S_RD_DATA;
          end
        end
      end

      // Stream the head message out, one byte store read a cycle.
      S_RD_DATA: begin
        if (issue_q != xfer_len_q) begin
          bs_re       = 1'b1;
          byte_head_d = ptr_inc(byte_head_q);
          issue_d     = issue_q + 1'b1;
          pend_d      = 1'b1;
        end
        if (pend_q) begin
          res_vld_d            = 1'b1;
          res_d.out_byte       = bs_rdata_q;
          res_d.last           = (issue_q == xfer_len_q);
          res_d.message_length = MSG_LEN_W'(xfer_len_q);
          if (issue_q == xfer_len_q) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Every beat reports the free space after its step.
    res_d.free_space = FREE_W'(SlotFull - used_d);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      byte_head_q <= '0;
      byte_tail_q <= '0;
      len_head_q  <= '0;
      len_tail_q  <= '0;
      msg_cnt_q   <= '0;
      used_q      <= '0;
      stg_cnt_q   <= '0;
      stg_ovf_q   <= 1'b0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      byte_head_q <= byte_head_d;
      byte_tail_q <= byte_tail_d;
      len_head_q  <= len_head_d;
      len_tail_q  <= len_tail_d;
      msg_cnt_q   <= msg_cnt_d;
      used_q      <= used_d;
      stg_cnt_q   <= stg_cnt_d;
      stg_ovf_q   <= stg_ovf_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      res_vld_q   <= res_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    xfer_len_q <= xfer_len_d;
    buf_len_q  <= buf_len_d;
    res_q      <= res_d;
  end

  // Staging buffer: written while idle, read during a commit.
  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      stg_mem[stg_cnt_q[SAW-1:0]] <= cmd_i.data_byte;
    end
    if (stg_re) begin
      stg_rdata_q <= stg_mem[issue_q[SAW-1:0]];
    end
  end

  // Byte store: written during a commit, read during a read, never both.
  always_ff @(posedge clk_i) begin
    if (bs_we) begin
      bs_mem[byte_tail_q] <= stg_rdata_q;
    end
    if (bs_re) begin
      bs_rdata_q <= bs_mem[byte_head_q];
    end
  end

  // Length queue: pushed at the end of a commit, head read at a read.
  always_ff @(posedge clk_i) begin
    if (lq_we) begin
      lq_mem[len_tail_q] <= MSG_LEN_W'(xfer_len_q);
    end
    if (lq_re) begin
      lq_rdata_q <= lq_mem[len_head_q];
    end
  end

  // Configuration registers.
  assign cfg_wr      = psel && penable && pwrite;
  assign cfg_max_seg = pwdata[MSG_LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seg_q  <= MaxSegLim;
      wr_nonbl_q <= 1'b0;
      rd_nonbl_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[REG_IDX_W+1:2])
        REG_MAX_SEG: begin
          if ((cfg_max_seg != '0) && (cfg_max_seg <= MaxSegLim)) begin
            max_seg_q <= cfg_max_seg;
          end
        end
        REG_WR_NONBL: begin
          wr_nonbl_q <= pwdata[0];
        end
        REG_RD_NONBL: begin
          rd_nonbl_q <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[REG_IDX_W+1:2])
      REG_MAX_SEG:  prdata = APB_DATA_W'(max_seg_q);
      REG_WR_NONBL: prdata = APB_DATA_W'(wr_nonbl_q);
      REG_RD_NONBL: prdata = APB_DATA_W'(rd_nonbl_q);
      default:      prdata = '0;
    endcase
  end

  assign pready       = 1'b1;
  assign res_strobe_o = res_vld_q;
  assign res_o        = res_q;

endmodule

// File: verif/tb.sv
// Testbench for message_fifo_with_size_limits_core: command beats, APB register writes,
// and a scoreboard that predicts every result beat. Depends on mfsl_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import mfsl_pkg::*;

  localparam int unsigned SLOT    = 1024;
  localparam int unsigned MAX_MSG = 64;
  localparam int unsigned PTR_W   = $clog2(SLOT);

  // Command code that the block treats as a no-op.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Scoreboard: a private copy of the slot state that predicts result beats.
  class slot_scoreboard;
    logic [7:0]       byte_mem [SLOT];
    logic [6:0]       size_mem [SLOT];
    logic [7:0]       stage_mem [MAX_MSG];
    logic [PTR_W-1:0] byte_rd, byte_wr, size_rd, size_wr;
    logic [10:0]      msg_cnt, used;
    logic [6:0]       stage_cnt;
    bit               stage_ovf;
    logic [6:0]       seg_limit;
    bit               wr_nonblock, rd_nonblock;
    res_t             expected_beats[$];
    int unsigned      errors, cmd_count, beat_count, stored_msgs, delivered_msgs;
    int unsigned      outcome [5];

    function new();
      byte_rd = '0;
      byte_wr = '0;
      size_rd = '0;
      size_wr = '0;
      msg_cnt = '0;
      used = '0;
      stage_cnt = '0;
      stage_ovf = 1'b0;
      seg_limit = 7'(MAX_MSG);
      wr_nonblock = 1'b0;
      rd_nonblock = 1'b0;
      errors = 0;
      cmd_count = 0;
      beat_count = 0;
      stored_msgs = 0;
      delivered_msgs = 0;
      foreach (outcome[i]) outcome[i] = 0;
    endfunction

    // Free space is always reported as it stands after the command.
    function void queue_beat(status_e st, logic [7:0] b, bit lst, logic [6:0] len);
      res_t r;
      r.status = st;
      r.out_byte = b;
      r.last = lst;
      r.free_space = FREE_W'(SLOT - used);
      r.message_length = len;
      expected_beats.push_back(r);
      if (lst) outcome[st]++;
    endfunction

    // Out-of-range segment limits are ignored; the mode bits use bit 0 only.
    function void set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_MAX_SEG: begin
          if (value[6:0] >= 7'd1 && value[6:0] <= 7'(MAX_MSG)) seg_limit = value[6:0];
        end
        REG_WR_NONBL: wr_nonblock = value[0];
        REG_RD_NONBL: rd_nonblock = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned head_length();
      return (msg_cnt != '0) ? int'(size_mem[size_rd]) : 0;
    endfunction

    // Work out the result beats of one accepted command.
    function void note_command(cmd_t c);
      int unsigned len;
      int unsigned i;
      cmd_count++;
      case (c.mode)
        MODE_STAGE: begin
          if (stage_cnt < 7'(MAX_MSG)) begin
            stage_mem[stage_cnt] = c.data_byte;
            stage_cnt++;
          end else begin
            stage_ovf = 1'b1;
          end
          queue_beat(ST_OK, '0, 1'b1, '0);
        end
        MODE_COMMIT: begin
          len = stage_cnt;
          if (stage_ovf || len == 0 || len > seg_limit) begin
            stage_cnt = '0;
            stage_ovf = 1'b0;
            queue_beat(ST_BADLEN, '0, 1'b1, '0);
          end else if (len > SLOT - used || msg_cnt >= SLOT) begin
            // No room: blocking keeps the staged bytes for a later commit.
            if (wr_nonblock) begin
              stage_cnt = '0;
              stage_ovf = 1'b0;
              queue_beat(ST_AGAIN, '0, 1'b1, '0);
            end else begin
              queue_beat(ST_WAIT, '0, 1'b1, '0);
            end
          end else begin
            for (i = 0; i < len; i++) begin
              byte_mem[byte_wr] = stage_mem[i];
              byte_wr++;
            end
            size_mem[size_wr] = 7'(len);
            size_wr++;
            msg_cnt++;
            used += 11'(len);
            stored_msgs++;
            stage_cnt = '0;
            stage_ovf = 1'b0;
            queue_beat(ST_OK, '0, 1'b1, 7'(len));
          end
        end
        MODE_READ: begin
          if (c.length == '0) begin
            queue_beat(ST_BADLEN, '0, 1'b1, '0);
          end else if (msg_cnt == '0) begin
            if (rd_nonblock) queue_beat(ST_AGAIN, '0, 1'b1, '0);
            else queue_beat(ST_WAIT, '0, 1'b1, '0);
          end else begin
            len = size_mem[size_rd];
            if (c.length < len) begin
              queue_beat(ST_SMALL, '0, 1'b1, '0);
            end else begin
              // The whole head message leaves, one beat per byte.
              size_rd++;
              msg_cnt--;
              used -= 11'(len);
              delivered_msgs++;
              for (i = 0; i < len; i++) begin
                queue_beat(ST_OK, byte_mem[byte_rd], (i + 1 == len), 7'(len));
                byte_rd++;
              end
            end
          end
        end
        default: queue_beat(ST_OK, '0, 1'b1, '0);
      endcase
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_beat(res_t got);
      res_t want;
      beat_count++;
      if (expected_beats.size() == 0) begin
        $error("Result beat with nothing pending: status %0d, byte %0h",
               got.status, got.out_byte);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
      if (got.free_space !== want.free_space) begin
        $error("free_space: expected %0d, actual %0d", want.free_space, got.free_space);
        errors++;
      end
      if (got.message_length !== want.message_length) begin
        $error("message_length: expected %0d, actual %0d",
               want.message_length, got.message_length);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  cmd_t                  cmd_i;
  logic                  busy_o;
  logic                  res_strobe_o;
  res_t                  res_o;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  slot_scoreboard sb;
  bit             idle_en;

  message_fifo_with_size_limits_core #(
    .SLOT_BYTES       (SLOT),
    .MAX_MESSAGE_BYTES(MAX_MSG)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // Result beats are sampled mid-cycle, away from the driving edge.
  always @(negedge clk_i) begin
    if (rst_ni && res_strobe_o) sb.check_beat(res_o);
  end

  // Present one command beat and hold it until the block takes it.
  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [7:0] b,
                          input logic [15:0] len);
    cmd_t c;
    c.mode = mode;
    c.data_byte = b;
    c.length = len;
    start_i <= 1'b1;
    cmd_i <= c;
    do @(negedge clk_i); while (busy_o);
    sb.note_command(c);
    @(posedge clk_i);
    if (idle_en && $urandom_range(0, 99) < 20) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // APB write: setup phase, access phase, then idle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    sb.set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let every pending result drain so the block is idle.
  task automatic settle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (sb.expected_beats.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  // Message sizes: mostly legal, with empty, over-limit and overflowing ones mixed in.
  function automatic int unsigned pick_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 4) return 0;
    if (k < 9) return $urandom_range(MAX_MSG + 1, MAX_MSG + 6);
    if (k < 15) return sb.seg_limit + 1;
    if (k < 22) return sb.seg_limit;
    if (k < 35) return $urandom_range(1, MAX_MSG);
    return $urandom_range(1, sb.seg_limit);
  endfunction

  // Reader buffer lengths clustered around the size of the head message.
  function automatic logic [15:0] pick_read_len();
    int unsigned h, k;
    h = sb.head_length();
    k = $urandom_range(0, 99);
    if (k < 6) return '0;
    if (k < 22 && h > 1) return 16'($urandom_range(1, h - 1));
    if (k < 50 && h > 0) return 16'(h);
    if (k < 62) return 16'hFFFF;
    return 16'($urandom_range((h > 0) ? h : 1, 65535));
  endfunction

  task automatic send_message(input int unsigned n);
    repeat (n) send_cmd(MODE_STAGE, 8'($urandom), 16'($urandom));
    send_cmd(MODE_COMMIT, 8'($urandom), 16'($urandom));
  endtask

  // Random traffic: staged messages, reads and a little noise. With fill set the
  // phase also stops once less than one full message of space is left.
  task automatic run_mix(input int unsigned budget, input int unsigned read_pct,
                         input bit fill);
    int unsigned phase_start, k;
    phase_start = sb.cmd_count;
    while (sb.cmd_count - phase_start < budget && !(fill && SLOT - sb.used < MAX_MSG)) begin
      k = $urandom_range(0, 99);
      if (k < read_pct) begin
        send_cmd(MODE_READ, 8'($urandom), pick_read_len());
      end else if (k < read_pct + 3) begin
        send_cmd(MODE_UNUSED, 8'($urandom), 16'($urandom));
      end else if (k < read_pct + 6) begin
        send_cmd(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
      end else begin
        send_message(pick_size());
      end
    end
  endtask

  initial begin
    sb = new();
    idle_en = 1'b1;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    cmd_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty reads, zero lengths, empty commit, unused code, one message.
    send_cmd(MODE_READ, 8'hA5, 16'd5);
    send_cmd(MODE_READ, 8'h00, 16'h0000);
    send_cmd(MODE_COMMIT, 8'h00, 16'h0000);
    send_cmd(MODE_UNUSED, 8'hFF, 16'hFFFF);
    send_cmd(MODE_STAGE, 8'h00, 16'hFFFF);
    send_cmd(MODE_STAGE, 8'hFF, 16'h0000);
    send_cmd(MODE_COMMIT, 8'h5A, 16'h1234);
    send_cmd(MODE_READ, 8'h00, 16'd1);
    send_cmd(MODE_READ, 8'hFF, 16'hFFFF);

    // Non-blocking modes and a segment limit of two.
    settle();
    write_reg(REG_RD_NONBL, 32'h1);
    write_reg(REG_WR_NONBL, 32'hFFFF_FFFF);
    write_reg(REG_MAX_SEG, 32'd2);
    send_cmd(MODE_READ, 8'h00, 16'h8000);
    send_cmd(MODE_STAGE, 8'h80, 16'h0000);
    send_cmd(MODE_STAGE, 8'h7F, 16'h0000);
    send_cmd(MODE_STAGE, 8'h01, 16'h0000);
    send_cmd(MODE_COMMIT, 8'h00, 16'h0000);
    send_cmd(MODE_STAGE, 8'hC3, 16'h0000);
    send_cmd(MODE_STAGE, 8'h3C, 16'h0000);
    send_cmd(MODE_COMMIT, 8'h00, 16'h0000);
    send_cmd(MODE_READ, 8'h00, 16'd2);

    // Out-of-range limits are ignored; upper register bits do not matter.
    settle();
    write_reg(REG_MAX_SEG, 32'd0);
    write_reg(REG_MAX_SEG, 32'd65);
    write_reg(REG_MAX_SEG, 32'hFFFF_FF81);
    write_reg(REG_WR_NONBL, 32'hFFFF_FFFE);
    write_reg(REG_RD_NONBL, 32'd2);

    // One-byte limit, blocking, with back-to-back commands throughout.
    idle_en = 1'b0;
    run_mix(50, 35, 1'b0);
    idle_en = 1'b1;

    // Full-size messages, both sides non-blocking.
    settle();
    write_reg(REG_MAX_SEG, 32'd64);
    write_reg(REG_WR_NONBL, 32'd1);
    write_reg(REG_RD_NONBL, 32'd1);
    run_mix(80, 35, 1'b0);

    // Store messages, with reads only from random noise commands, stopping short of a full slot.
    settle();
    write_reg(REG_WR_NONBL, 32'd0);
    write_reg(REG_RD_NONBL, 32'd0);
    run_mix(50, 0, 1'b1);

    // Non-blocking commits with a lower limit, then drain.
    settle();
    write_reg(REG_WR_NONBL, 32'd1);
    write_reg(REG_MAX_SEG, 32'd48);
    run_mix(20, 0, 1'b0);
    run_mix(50, 60, 1'b0);

    // Random register settings.
    settle();
    write_reg(REG_MAX_SEG, 32'($urandom_range(1, MAX_MSG)));
    write_reg(REG_WR_NONBL, $urandom);
    write_reg(REG_RD_NONBL, $urandom);
    run_mix(50, 40, 1'b0);

    // Empty the slot and read once more from the empty slot.
    while (sb.msg_cnt != '0) send_cmd(MODE_READ, 8'($urandom), 16'hFFFF);
    send_cmd(MODE_READ, 8'($urandom), 16'hFFFF);

    settle();
    repeat (70) @(posedge clk_i);
    $display("Run covered %0d commands and %0d result beats; %0d messages stored, %0d read out.",
             sb.cmd_count, sb.beat_count, sb.stored_msgs, sb.delivered_msgs);
    $display("Outcomes: ok %0d, wait %0d, try again %0d, bad length %0d, buffer too small %0d.",
             sb.outcome[ST_OK], sb.outcome[ST_WAIT], sb.outcome[ST_AGAIN],
             sb.outcome[ST_BADLEN], sb.outcome[ST_SMALL]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: stops a hung run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
